// ----- hdl/ssab_pkg.sv -----
// Shared types and constants for the scaled sprite alpha blitter.
// No dependencies; the top level, ssab_coord and ssab_mix import this package.
package ssab_pkg;

   localparam int DEF_MAX_SPRITE_SIDE = 64;
   localparam int DEF_MAX_SCREEN_SIDE = 4096;
   localparam int DEF_MAX_SCALE       = 8;

   localparam int PIX_W       = 32;
   localparam int CHAN_W      = 8;
   localparam int COORD_W     = 12;
   localparam int ADDR_W      = 12;
   localparam int STORE_DEPTH = 4096;
   localparam int DX_W        = 14;
   localparam int CMP_W       = 14;
   localparam int SCR_CFG_W   = 13;
   localparam int SPR_CFG_W   = 7;
   localparam int POS_CFG_W   = 13;
   localparam int SCL_CFG_W   = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_BLEND = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SCREEN_WIDTH  = 3'd0,
      REG_SCREEN_HEIGHT = 3'd1,
      REG_SPRITE_WIDTH  = 3'd2,
      REG_SPRITE_HEIGHT = 3'd3,
      REG_PLACE_X       = 3'd4,
      REG_PLACE_Y       = 3'd5,
      REG_SCALE_FACTOR  = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [SCR_CFG_W-1:0] screen_width;
      logic [SCR_CFG_W-1:0] screen_height;
      logic [SPR_CFG_W-1:0] sprite_width;
      logic [SPR_CFG_W-1:0] sprite_height;
      logic [POS_CFG_W-1:0] place_x;
      logic [POS_CFG_W-1:0] place_y;
      logic [SCL_CFG_W-1:0] scale_factor;
   } cfg_type;

   // Beat leaving the coordinate pipe: a texel write or a blend lookup.
   typedef struct packed {
      logic              valid;
      logic              is_load;
      logic              covered;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  data;
   } addr_beat_type;

   // Blend beat aligned with the texel store read data.
   typedef struct packed {
      logic             valid;
      logic             covered;
      logic [PIX_W-1:0] dest;
   } blend_beat_type;

endpackage

// ----- hdl/scaled_sprite_alpha_blit.sv -----
// Top level of the scaled sprite alpha blitter: registers, texel store, pipes.
// Depends on ssab_pkg, ssab_ram, ssab_coord and ssab_mix.
//
// Sprite overlay engine. Load the sprite first with req_type 0 beats (one
// RGBA8 texel each, row major, red in the low byte); these give no response.
// Then send destination pixels with req_type 1: each gives exactly one
// response, blended with the nearest texel of the sprite upscaled by
// scale_factor at (place_x, place_y), or passed through with rsp_covered low
// when it lies off screen or outside the rectangle. One beat is taken every
// clock unless req_stall is high; a pixel passes four coordinate stages, the
// texel store read and two blend stages on its way to its response. Texel
// loads and lookups reach the store in acceptance order, so a sprite can be
// reloaded mid stream. Write the registers only while the block is idle.
module scaled_sprite_alpha_blit #(
   parameter int MAX_SPRITE_SIDE = ssab_pkg::DEF_MAX_SPRITE_SIDE,
   parameter int MAX_SCREEN_SIDE = ssab_pkg::DEF_MAX_SCREEN_SIDE,
   parameter int MAX_SCALE       = ssab_pkg::DEF_MAX_SCALE
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_type,
   input  logic [ssab_pkg::COORD_W-1:0]    req_texel_index,
   input  logic [ssab_pkg::PIX_W-1:0]      req_texel_value,
   input  logic [ssab_pkg::COORD_W-1:0]    req_pixel_x,
   input  logic [ssab_pkg::COORD_W-1:0]    req_pixel_y,
   input  logic [ssab_pkg::PIX_W-1:0]      req_dest_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ssab_pkg::PIX_W-1:0]      rsp_pixel_out,
   output logic                            rsp_covered,
   input  logic                            csr_we,
   input  logic [ssab_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssab_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import ssab_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= SCR_CFG_W'(640);
         cfg_ff.screen_height <= SCR_CFG_W'(480);
         cfg_ff.sprite_width  <= SPR_CFG_W'(64);
         cfg_ff.sprite_height <= SPR_CFG_W'(64);
         cfg_ff.place_x       <= '0;
         cfg_ff.place_y       <= '0;
         cfg_ff.scale_factor  <= SCL_CFG_W'(1);
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_wdata[SCR_CFG_W-1:0];
            REG_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_wdata[SCR_CFG_W-1:0];
            REG_SPRITE_WIDTH:  cfg_ff.sprite_width  <= csr_wdata[SPR_CFG_W-1:0];
            REG_SPRITE_HEIGHT: cfg_ff.sprite_height <= csr_wdata[SPR_CFG_W-1:0];
            REG_PLACE_X:       cfg_ff.place_x       <= csr_wdata[POS_CFG_W-1:0];
            REG_PLACE_Y:       cfg_ff.place_y       <= csr_wdata[POS_CFG_W-1:0];
            REG_SCALE_FACTOR:  cfg_ff.scale_factor  <= csr_wdata[SCL_CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   addr_beat_type  abeat;
   blend_beat_type blend_ff;
   logic           en5, mix_take;
   logic [PIX_W-1:0] texel;

   ssab_coord #(
      .MAX_SPRITE_SIDE(MAX_SPRITE_SIDE),
      .MAX_SCREEN_SIDE(MAX_SCREEN_SIDE),
      .MAX_SCALE(MAX_SCALE)
   ) u_coord (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_texel_index(req_texel_index),
      .req_texel_value(req_texel_value),
      .req_pixel_x(req_pixel_x),
      .req_pixel_y(req_pixel_y),
      .req_dest_pixel(req_dest_pixel),
      .down_en(en5),
      .beat(abeat)
   );

   // store access stage: loads write here and drop, blends read
   assign en5 = !blend_ff.valid || mix_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_ff.valid <= 1'b0;
      end else if (en5) begin
         blend_ff.valid <= abeat.valid && !abeat.is_load;
      end
      if (en5) begin
         blend_ff.covered <= abeat.covered;
         blend_ff.dest    <= abeat.data;
      end
   end

   ssab_ram #(
      .WIDTH(PIX_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock(clock),
      .we(en5 && abeat.valid && abeat.is_load),
      .waddr(abeat.addr),
      .wdata(abeat.data),
      .re(en5),
      .raddr(abeat.addr),
      .rdata(texel)
   );

   ssab_mix u_mix (
      .clock(clock),
      .reset(reset),
      .blend(blend_ff),
      .texel(texel),
      .take(mix_take),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pixel_out(rsp_pixel_out),
      .rsp_covered(rsp_covered)
   );

endmodule

// ----- hdl/ssab_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module ssab_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/ssab_coord.sv -----
// Coordinate pipe: clipping, rectangle test and texel address, four stages.
// Depends on ssab_pkg.
module ssab_coord #(
   parameter int MAX_SPRITE_SIDE = ssab_pkg::DEF_MAX_SPRITE_SIDE,
   parameter int MAX_SCREEN_SIDE = ssab_pkg::DEF_MAX_SCREEN_SIDE,
   parameter int MAX_SCALE       = ssab_pkg::DEF_MAX_SCALE
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ssab_pkg::cfg_type             cfg,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [ssab_pkg::COORD_W-1:0]  req_texel_index,
   input  logic [ssab_pkg::PIX_W-1:0]    req_texel_value,
   input  logic [ssab_pkg::COORD_W-1:0]  req_pixel_x,
   input  logic [ssab_pkg::COORD_W-1:0]  req_pixel_y,
   input  logic [ssab_pkg::PIX_W-1:0]    req_dest_pixel,
   input  logic                          down_en,
   output ssab_pkg::addr_beat_type       beat
);

   import ssab_pkg::*;

   localparam int SCR_W = $clog2(MAX_SCREEN_SIDE + 1);
   localparam int SPR_W = $clog2(MAX_SPRITE_SIDE + 1);
   localparam int SCL_W = $clog2(MAX_SCALE + 1);
   localparam int EXT_W = SPR_W + SCL_W;
   localparam int K     = EXT_W + SCL_W;
   localparam int R_W   = K + 1;
   localparam int PRD_W = EXT_W + R_W;
   localparam int IDX_W = 2 * SPR_W;
   localparam int SPR_T = 9;
   localparam int SCL_T = 5;

   // reciprocal table, ceil(2^K / s), exact quotient for any in-range offset
   logic [R_W-1:0] rcp_tab [2**SCL_W];
   for (genvar s = 0; s < 2**SCL_W; s++) begin : g_rcp
      localparam int D   = (s == 0) ? 1 : s;
      localparam int RCP = ((2**K) + D - 1) / D;
      assign rcp_tab[s] = R_W'(RCP);
   end

   // derived configuration
   logic [CMP_W-1:0] scr_w_t, scr_h_t;
   logic [SPR_T-1:0] spr_w_t, spr_h_t;
   logic [SCL_T-1:0] scl_t;
   logic [SCR_W-1:0] scr_w_in, scr_h_in, scr_w_ff, scr_h_ff;
   logic [SPR_W-1:0] spr_w_in, spr_h_in, spr_w_ff;
   logic [SCL_W-1:0] scl_in;
   logic [EXT_W-1:0] ext_w_in, ext_h_in, ext_w_ff, ext_h_ff;
   logic [R_W-1:0]   rcp_in, rcp_ff;

   always_comb begin
      scr_w_t = CMP_W'(cfg.screen_width);
      scr_h_t = CMP_W'(cfg.screen_height);
      spr_w_t = SPR_T'(cfg.sprite_width);
      spr_h_t = SPR_T'(cfg.sprite_height);
      scl_t   = SCL_T'(cfg.scale_factor);
      if (scr_w_t > CMP_W'(MAX_SCREEN_SIDE)) begin
         scr_w_t = CMP_W'(MAX_SCREEN_SIDE);
      end
      if (scr_h_t > CMP_W'(MAX_SCREEN_SIDE)) begin
         scr_h_t = CMP_W'(MAX_SCREEN_SIDE);
      end
      if (spr_w_t > SPR_T'(MAX_SPRITE_SIDE)) begin
         spr_w_t = SPR_T'(MAX_SPRITE_SIDE);
      end
      if (spr_h_t > SPR_T'(MAX_SPRITE_SIDE)) begin
         spr_h_t = SPR_T'(MAX_SPRITE_SIDE);
      end
      if (scl_t > SCL_T'(MAX_SCALE)) begin
         scl_t = SCL_T'(MAX_SCALE);
      end
      if (scl_t == '0) begin
         scl_t = SCL_T'(1);
      end
      scr_w_in = SCR_W'(scr_w_t);
      scr_h_in = SCR_W'(scr_h_t);
      spr_w_in = SPR_W'(spr_w_t);
      spr_h_in = SPR_W'(spr_h_t);
      scl_in   = SCL_W'(scl_t);
      ext_w_in = EXT_W'(spr_w_in) * EXT_W'(scl_in);
      ext_h_in = EXT_W'(spr_h_in) * EXT_W'(scl_in);
      rcp_in   = rcp_tab[scl_in];
   end

   always_ff @(posedge clock) begin
      scr_w_ff <= scr_w_in;
      scr_h_ff <= scr_h_in;
      spr_w_ff <= spr_w_in;
      ext_w_ff <= ext_w_in;
      ext_h_ff <= ext_h_in;
      rcp_ff   <= rcp_in;
   end

   // stage enables
   logic en1, en2, en3, en4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   assign en4       = !v4_ff || down_en;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = reset || !en1;

   // stage 1: capture
   logic               typ1_ff;
   logic [ADDR_W-1:0]  tidx1_ff;
   logic [PIX_W-1:0]   data1_ff;
   logic [COORD_W-1:0] px1_ff, py1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_valid;
      end
      if (en1) begin
         typ1_ff  <= req_type;
         tidx1_ff <= ADDR_W'(req_texel_index);
         data1_ff <= (req_type == REQ_LOAD) ? req_texel_value : req_dest_pixel;
         px1_ff   <= req_pixel_x;
         py1_ff   <= req_pixel_y;
      end
   end

   // stage 2: offsets from the sprite corner, screen clip
   logic              typ2_ff, onscr2_ff;
   logic [ADDR_W-1:0] tidx2_ff;
   logic [PIX_W-1:0]  data2_ff;
   logic [DX_W-1:0]   dx2_ff, dy2_ff;
   logic [DX_W-1:0]   dx2_in, dy2_in;
   logic              onscr2_in;

   always_comb begin
      dx2_in = DX_W'(px1_ff) - {cfg.place_x[POS_CFG_W-1], cfg.place_x};
      dy2_in = DX_W'(py1_ff) - {cfg.place_y[POS_CFG_W-1], cfg.place_y};
      onscr2_in = (CMP_W'(px1_ff) < CMP_W'(scr_w_ff)) &&
                  (CMP_W'(py1_ff) < CMP_W'(scr_h_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
      if (en2) begin
         typ2_ff   <= typ1_ff;
         tidx2_ff  <= tidx1_ff;
         data2_ff  <= data1_ff;
         dx2_ff    <= dx2_in;
         dy2_ff    <= dy2_in;
         onscr2_ff <= onscr2_in;
      end
   end

   // stage 3: rectangle test, divide by scale through the reciprocal
   logic              typ3_ff, cov3_ff;
   logic [ADDR_W-1:0] tidx3_ff;
   logic [PIX_W-1:0]  data3_ff;
   logic [SPR_W-1:0]  qx3_ff, qy3_ff;
   logic [CMP_W-1:0]  dxm, dym;
   logic              cov3_in;
   logic [PRD_W-1:0]  prd_x, prd_y;

   always_comb begin
      dxm = {1'b0, dx2_ff[DX_W-2:0]};
      dym = {1'b0, dy2_ff[DX_W-2:0]};
      cov3_in = onscr2_ff && !dx2_ff[DX_W-1] && !dy2_ff[DX_W-1] &&
                (dxm < CMP_W'(ext_w_ff)) && (dym < CMP_W'(ext_h_ff));
      prd_x = PRD_W'(dx2_ff[EXT_W-1:0]) * PRD_W'(rcp_ff);
      prd_y = PRD_W'(dy2_ff[EXT_W-1:0]) * PRD_W'(rcp_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
      if (en3) begin
         typ3_ff  <= typ2_ff;
         tidx3_ff <= tidx2_ff;
         data3_ff <= data2_ff;
         cov3_ff  <= cov3_in;
         qx3_ff   <= prd_x[K +: SPR_W];
         qy3_ff   <= prd_y[K +: SPR_W];
      end
   end

   // stage 4: row major texel address, or the load's own texel index
   logic [IDX_W-1:0]  idx4;
   logic              typ4_ff, cov4_ff;
   logic [ADDR_W-1:0] addr4_ff;
   logic [PIX_W-1:0]  data4_ff;

   assign idx4 = IDX_W'(qy3_ff) * IDX_W'(spr_w_ff) + IDX_W'(qx3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en4) begin
         v4_ff <= v3_ff;
      end
      if (en4) begin
         typ4_ff  <= typ3_ff;
         cov4_ff  <= cov3_ff && (typ3_ff == REQ_BLEND);
         addr4_ff <= (typ3_ff == REQ_LOAD) ? tidx3_ff : ADDR_W'(idx4);
         data4_ff <= data3_ff;
      end
   end

   always_comb begin
      beat.valid   = v4_ff;
      beat.is_load = (typ4_ff == REQ_LOAD);
      beat.covered = cov4_ff;
      beat.addr    = addr4_ff;
      beat.data    = data4_ff;
   end

endmodule

// ----- hdl/ssab_mix.sv -----
// Alpha blend pipe: channel products, then sum, select and result register.
// Depends on ssab_pkg.
module ssab_mix (
   input  logic                       clock,
   input  logic                       reset,
   input  ssab_pkg::blend_beat_type   blend,
   input  logic [ssab_pkg::PIX_W-1:0] texel,
   output logic                       take,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [ssab_pkg::PIX_W-1:0] rsp_pixel_out,
   output logic                       rsp_covered
);

   import ssab_pkg::*;

   localparam int NCH   = 3;
   localparam int PROD_W = 2 * CHAN_W;
   localparam int SUM_W  = PROD_W + 1;

   logic en6, en_out;
   logic v6_ff, cov6_ff;
   logic [PIX_W-1:0]  tex6_ff, dest6_ff;
   logic [CHAN_W-1:0] alpha6_ff;
   logic [PROD_W-1:0] ps6_ff [NCH];
   logic [PROD_W-1:0] pd6_ff [NCH];
   logic [CHAN_W-1:0] alpha, inv;

   logic             rsp_valid_ff, rsp_covered_ff;
   logic [PIX_W-1:0] rsp_pixel_ff, pixel_in;
   logic [SUM_W-1:0] sum [NCH];

   assign en_out = !rsp_valid_ff || !rsp_stall;
   assign en6    = !v6_ff || en_out;
   assign take   = en6;

   assign alpha = texel[PIX_W-1 -: CHAN_W];
   assign inv   = ALPHA_OPAQUE - alpha;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en6) begin
         v6_ff <= blend.valid;
      end
      if (en6) begin
         cov6_ff   <= blend.covered;
         tex6_ff   <= texel;
         dest6_ff  <= blend.dest;
         alpha6_ff <= alpha;
         for (int c = 0; c < NCH; c++) begin
            ps6_ff[c] <= PROD_W'(texel[c*CHAN_W +: CHAN_W]) * PROD_W'(alpha);
            pd6_ff[c] <= PROD_W'(blend.dest[c*CHAN_W +: CHAN_W]) * PROD_W'(inv);
         end
      end
   end

   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         sum[c] = SUM_W'(ps6_ff[c]) + SUM_W'(pd6_ff[c]);
      end
      if (!cov6_ff || alpha6_ff == ALPHA_CLEAR) begin
         pixel_in = dest6_ff;
      end else if (alpha6_ff == ALPHA_OPAQUE) begin
         pixel_in = tex6_ff;
      end else begin
         pixel_in[PIX_W-1 -: CHAN_W] = ALPHA_OPAQUE;
         for (int c = 0; c < NCH; c++) begin
            pixel_in[c*CHAN_W +: CHAN_W] = sum[c][CHAN_W +: CHAN_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= v6_ff;
      end
      if (en_out) begin
         rsp_pixel_ff   <= pixel_in;
         rsp_covered_ff <= cov6_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_covered   = rsp_covered_ff;

endmodule
